>>> rtl/stt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg
// shared types and constants of the software timer table
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned TIME_W = 64;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned CMD_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_TICK   = 2'd2
  } cmd_e;

  // one queued operation, already checked by the front end
  typedef struct packed {
    cmd_e              op;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now_ns;
    logic [TIME_W-1:0] duration_ns;
    logic [TIME_W-1:0] interval_ns;
    logic              is_periodic;
    logic              reuse_duration;
  } stt_op_t;

  // per-slot settings written only by an add
  typedef struct packed {
    logic [TIME_W-1:0] duration_ns;
    logic [TIME_W-1:0] interval_ns;
    logic              is_periodic;
    logic              reuse_duration;
  } stt_par_t;

endpackage
`default_nettype wire

>>> rtl/stt_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_if
// command and result channels of the software timer table
// ----------------------------------------------------------------------------
interface stt_cmd_if
  import stt_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic [SLOT_W-1:0]       slot;
  logic [TIME_W-1:0]       now_ns;
  logic [TIME_W-1:0]       duration_ns;
  logic [TIME_W-1:0]       interval_ns;
  logic                    is_periodic;
  logic                    reuse_duration;

  modport source (
    output valid, command, slot, now_ns, duration_ns, interval_ns, is_periodic,
           reuse_duration,
    input  ready
  );
  modport sink (
    input  valid, command, slot, now_ns, duration_ns, interval_ns, is_periodic,
           reuse_duration,
    output ready
  );
endinterface

interface stt_res_if
  import stt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] fired_slot;
  logic              last;

  modport source (output valid, fired_slot, last, input ready);
  modport sink   (input valid, fired_slot, last, output ready);
endinterface
`default_nettype wire

>>> rtl/software_timer_table_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// software_timer_table_unit
// table of one-shot and periodic timers driven by add, delete and tick beats
// ----------------------------------------------------------------------------
// Commands enter a two-entry queue and are executed one at a time. An add or
// a delete updates the table from the idle state of the execution engine. A
// tick scans one slot per cycle, unless the output stalls, through the single
// read address shared by the timer memories, and each expired slot is
// reported as one result beat, the final one flagged with last. An expired
// slot waits in a pending register until the next one is found or the scan
// ends, so that last can be set; a full output register stalls the scan.
// Deadlines and settings live in memories with no reset; of the table, only
// the active bits are cleared by reset, so the block is ready straight after reset.
module software_timer_table_unit
  import stt_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  stt_cmd_if.sink      cmd_i,
  stt_res_if.source    res_o
);

  logic    q_valid;
  logic    q_ready;
  stt_op_t q_op;

  stt_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_i),
    .q_valid_o (q_valid),
    .q_op_o    (q_op),
    .q_ready_i (q_ready)
  );

  stt_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_op_i    (q_op),
    .q_ready_o (q_ready),
    .res_o     (res_o)
  );

endmodule
`default_nettype wire

>>> rtl/stt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_front
// accepts command beats, drops ones with no effect, queues the rest
// ----------------------------------------------------------------------------
module stt_front
  import stt_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  stt_cmd_if.sink      cmd_i,
  output logic         q_valid_o,
  output stt_op_t      q_op_o,
  input  wire          q_ready_i
);

  localparam int unsigned DEPTH = 2;

  stt_op_t    ent_q [DEPTH];
  logic       wp_q, wp_d;
  logic       rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  stt_op_t op;
  logic    in_range;
  logic    keep;
  logic    push;
  logic    pop;

  assign cmd_i.ready = (cnt_q != 2'(DEPTH));
  assign in_range    = 7'(cmd_i.slot) < 7'(NUM_SLOTS);

  always_comb begin
    op.op             = CMD_TICK;
    op.slot           = cmd_i.slot;
    op.now_ns         = cmd_i.now_ns;
    op.duration_ns    = cmd_i.duration_ns;
    op.interval_ns    = cmd_i.interval_ns;
    op.is_periodic    = cmd_i.is_periodic;
    op.reuse_duration = cmd_i.reuse_duration;
    keep              = 1'b0;
    unique case (cmd_i.command)
      CMD_ADD: begin
        op.op = CMD_ADD;
        keep  = in_range;
      end
      CMD_DELETE: begin
        op.op = CMD_DELETE;
        keep  = in_range;
      end
      CMD_TICK: begin
        op.op = CMD_TICK;
        keep  = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign push      = cmd_i.valid && cmd_i.ready && keep;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_op_o    = ent_q[rp_q];
  assign pop       = q_valid_o && q_ready_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= op;
    end
  end

endmodule
`default_nettype wire

>>> rtl/stt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_back
// executes queued operations: table updates and the expiry scan of a tick
// ----------------------------------------------------------------------------
module stt_back
  import stt_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          q_valid_i,
  input  stt_op_t      q_op_i,
  output logic         q_ready_o,
  stt_res_if.source    res_o
);

  localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_e;

  state_e             state_q, state_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [TIME_W-1:0]  tick_count_q, tick_count_d;
  logic [NUM_SLOTS-1:0] active_q, active_d;
  logic               pend_v_q, pend_v_d;
  logic [IW-1:0]      pend_q, pend_d;
  logic               ov_q, ov_d;
  logic [SLOT_W-1:0]  ofs_q, ofs_d;
  logic               olast_q, olast_d;

  // timer memories
  logic [TIME_W-1:0]  dl_mem [NUM_SLOTS];
  stt_par_t           par_mem [NUM_SLOTS];
  logic [TIME_W-1:0]  dl_rd_q;
  stt_par_t           par_rd_q;

  logic [IW-1:0]      raddr;
  logic               dl_we;
  logic [IW-1:0]      dl_wa;
  logic [TIME_W-1:0]  dl_wd;
  logic               par_we;
  stt_par_t           par_wd;

  logic [IW-1:0]      op_idx;
  logic [31:0]        op_slot_ext;
  logic               pop;
  logic               fire;
  logic               out_free;
  logic               advance;
  logic [TIME_W-1:0]  rearm;

  assign op_slot_ext = 32'(q_op_i.slot);
  assign op_idx      = op_slot_ext[IW-1:0];
  assign q_ready_o   = (state_q == S_IDLE);
  assign pop         = q_valid_i && q_ready_o;
  assign out_free    = !ov_q || res_o.ready;
  assign fire        = active_q[idx_q] && (now_q > dl_rd_q);
  assign advance     = !(fire && pend_v_q && !out_free);
  assign rearm       = now_q + (par_rd_q.reuse_duration ? par_rd_q.duration_ns
                                                        : par_rd_q.interval_ns);

  function automatic logic [SLOT_W-1:0] to_slot(input logic [IW-1:0] i);
    logic [31:0] e;
    e = 32'(i);
    return e[SLOT_W-1:0];
  endfunction

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    now_d        = now_q;
    tick_count_d = tick_count_q;
    active_d     = active_q;
    pend_v_d     = pend_v_q;
    pend_d       = pend_q;
    ov_d         = ov_q && !res_o.ready;
    ofs_d        = ofs_q;
    olast_d      = olast_q;
    raddr        = '0;
    dl_we        = 1'b0;
    dl_wa        = idx_q;
    dl_wd        = rearm;
    par_we       = 1'b0;
    par_wd.duration_ns    = q_op_i.duration_ns;
    par_wd.interval_ns    = q_op_i.interval_ns;
    par_wd.is_periodic    = q_op_i.is_periodic;
    par_wd.reuse_duration = q_op_i.reuse_duration;

    unique case (state_q)
      S_IDLE: begin
        if (pop) begin
          unique case (q_op_i.op)
            CMD_ADD: begin
              dl_we            = 1'b1;
              dl_wa            = op_idx;
              dl_wd            = q_op_i.now_ns + q_op_i.duration_ns;
              par_we           = 1'b1;
              active_d[op_idx] = 1'b1;
            end
            CMD_DELETE: begin
              active_d[op_idx] = 1'b0;
            end
            CMD_TICK: begin
              tick_count_d = tick_count_q + TIME_W'(1);
              now_d        = q_op_i.now_ns;
              idx_d        = '0;
              state_d      = S_SCAN;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        raddr = advance ? idx_q + IW'(1) : idx_q;
        if (advance) begin
          if (fire) begin
            if (pend_v_q) begin
              ov_d    = 1'b1;
              ofs_d   = to_slot(pend_q);
              olast_d = 1'b0;
            end
            pend_v_d = 1'b1;
            pend_d   = idx_q;
            if (par_rd_q.is_periodic) begin
              dl_we = 1'b1;
            end else begin
              active_d[idx_q] = 1'b0;
            end
          end
          if (idx_q == LAST_IDX) begin
            state_d = S_FLUSH;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end
      S_FLUSH: begin
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          ov_d     = 1'b1;
          ofs_d    = to_slot(pend_q);
          olast_d  = 1'b1;
          pend_v_d = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      now_q        <= '0;
      tick_count_q <= '0;
      active_q     <= '0;
      pend_v_q     <= 1'b0;
      pend_q       <= '0;
      ov_q         <= 1'b0;
      ofs_q        <= '0;
      olast_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      now_q        <= now_d;
      tick_count_q <= tick_count_d;
      active_q     <= active_d;
      pend_v_q     <= pend_v_d;
      pend_q       <= pend_d;
      ov_q         <= ov_d;
      ofs_q        <= ofs_d;
      olast_q      <= olast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dl_we) begin
      dl_mem[dl_wa] <= dl_wd;
    end
    dl_rd_q <= dl_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (par_we) begin
      par_mem[op_idx] <= par_wd;
    end
    par_rd_q <= par_mem[raddr];
  end

  assign res_o.valid      = ov_q;
  assign res_o.fired_slot = ofs_q;
  assign res_o.last       = olast_q;

endmodule
`default_nettype wire

>>> rtl/stt_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stt_checker
// port-level checks of the software timer table
// ----------------------------------------------------------------------------
module stt_checker
  import stt_pkg::*;
(
  input wire              clk_i,
  input wire              rst_ni,
  input wire              cmd_valid_i,
  input wire              cmd_ready_i,
  input wire [CMD_W-1:0]  command_i,
  input wire              res_valid_i,
  input wire              res_ready_i,
  input wire [SLOT_W-1:0] fired_slot_i,
  input wire              last_i
);

  logic              tick_seen_q;
  logic              in_tick_q;
  logic [SLOT_W-1:0] prev_q;
  logic              res_beat;

  assign res_beat = res_valid_i && res_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_seen_q <= 1'b0;
      in_tick_q   <= 1'b0;
      prev_q      <= '0;
    end else begin
      if (cmd_valid_i && cmd_ready_i && command_i == CMD_TICK) begin
        tick_seen_q <= 1'b1;
      end
      if (res_beat) begin
        in_tick_q <= !last_i;
        prev_q    <= fired_slot_i;
      end
    end
  end

  a_valid_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result valid dropped while stalled");

  a_data_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(fired_slot_i) && $stable(last_i))
    else $error("result payload changed while stalled");

  a_needs_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> tick_seen_q)
    else $error("result with no tick accepted");

  a_slot_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_beat && in_tick_q |-> fired_slot_i > prev_q)
    else $error("expired slots of one tick out of order");

endmodule

bind software_timer_table_unit stt_checker u_stt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid_i  (cmd_i.valid),
  .cmd_ready_i  (cmd_i.ready),
  .command_i    (cmd_i.command),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .fired_slot_i (res_o.fired_slot),
  .last_i       (res_o.last)
);
`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// self-checking regression of the software timer table
// ----------------------------------------------------------------------------
// Command beats go in through the command channel in bursts with random gaps.
// Result beats are taken on a random stall pattern, with one long hold-off
// that backs the table up into its command queue. A directed table comes
// first: after reset, the extremes of the time fields, wrapped deadlines,
// refresh, deletes and the spare command code. Random traffic follows, mostly
// adds and ticks on a moving time base, with full-table expiries, jumps of
// the time base near the top of its range and noise of full-width values.
// Each command is run through a local timer model when it is accepted; the
// slots it fires are queued and compared with the result beats in order.
// ----------------------------------------------------------------------------
module tb_top
  import stt_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_SLOTS    = 16;
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned HOLD_AT      = 80;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam logic [CMD_W-1:0]  CMD_SPARE = 2'd3;
  localparam logic [TIME_W-1:0] T_MAX     = '1;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] now_ns;
    logic [TIME_W-1:0] duration_ns;
    logic [TIME_W-1:0] interval_ns;
    logic              is_periodic;
    logic              reuse_duration;
  } cmd_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              last;
  } fire_t;

  typedef struct {
    cmd_item_t            item;
    bit                   typed;
    bit [NUM_SLOTS-1:0]   fired;
  } plan_row_t;

  logic clk_i;
  logic rst_ni;

  stt_cmd_if cmd_ch ();
  stt_res_if res_ch ();

  software_timer_table_unit #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_ch.sink),
    .res_o (res_ch.source)
  );

  // timer model state
  bit                armed     [NUM_SLOTS];
  logic [TIME_W-1:0] due_ns    [NUM_SLOTS];
  logic [TIME_W-1:0] span_ns   [NUM_SLOTS];
  logic [TIME_W-1:0] period_ns [NUM_SLOTS];
  bit                periodic  [NUM_SLOTS];
  bit                reuse     [NUM_SLOTS];
  logic [TIME_W-1:0] tick_total;

  fire_t       tick_fires[$];
  fire_t       pending_fires[$];
  plan_row_t   plan[$];
  int unsigned accepted_cmds;
  int unsigned burst_left;
  int unsigned mismatches;
  int unsigned quiet_cycles;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic cmd_item_t cmd_of(input logic [CMD_W-1:0] command,
                                       input logic [SLOT_W-1:0] slot,
                                       input logic [TIME_W-1:0] now_ns,
                                       input logic [TIME_W-1:0] duration_ns,
                                       input logic [TIME_W-1:0] interval_ns,
                                       input logic is_periodic,
                                       input logic reuse_duration);
    cmd_item_t c;
    c.command        = command;
    c.slot           = slot;
    c.now_ns         = now_ns;
    c.duration_ns    = duration_ns;
    c.interval_ns    = interval_ns;
    c.is_periodic    = is_periodic;
    c.reuse_duration = reuse_duration;
    return c;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    return {$urandom, $urandom};
  endfunction

  // applies one command to the timer model, leaving the slots it fires in tick_fires
  function automatic void advance_timers(input cmd_item_t c);
    fire_t f;
    tick_fires.delete();
    case (c.command)
      CMD_ADD: begin
        if (c.slot < NUM_SLOTS) begin
          due_ns[c.slot]    = c.now_ns + c.duration_ns;
          span_ns[c.slot]   = c.duration_ns;
          period_ns[c.slot] = c.interval_ns;
          periodic[c.slot]  = c.is_periodic;
          reuse[c.slot]     = c.reuse_duration;
          armed[c.slot]     = 1'b1;
        end
      end
      CMD_DELETE: begin
        if (c.slot < NUM_SLOTS) armed[c.slot] = 1'b0;
      end
      CMD_TICK: begin
        tick_total = tick_total + 1'b1;
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (armed[s] && c.now_ns > due_ns[s]) begin
            f.slot = SLOT_W'(s);
            f.last = 1'b0;
            tick_fires.push_back(f);
            if (periodic[s]) begin
              due_ns[s] = c.now_ns + (reuse[s] ? span_ns[s] : period_ns[s]);
            end else begin
              armed[s]   = 1'b0;
              due_ns[s]  = '0;
              span_ns[s] = '0;
            end
          end
        end
        if (tick_fires.size() != 0) begin
          f = tick_fires[tick_fires.size() - 1];
          f.last = 1'b1;
          tick_fires[tick_fires.size() - 1] = f;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic issue_cmd(input cmd_item_t c, input bit typed,
                           input bit [NUM_SLOTS-1:0] fired);
    fire_t f;
    if (burst_left == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    cmd_ch.valid          <= 1'b1;
    cmd_ch.command        <= c.command;
    cmd_ch.slot           <= c.slot;
    cmd_ch.now_ns         <= c.now_ns;
    cmd_ch.duration_ns    <= c.duration_ns;
    cmd_ch.interval_ns    <= c.interval_ns;
    cmd_ch.is_periodic    <= c.is_periodic;
    cmd_ch.reuse_duration <= c.reuse_duration;
    do @(posedge clk_i); while (cmd_ch.ready !== 1'b1);
    accepted_cmds++;
    advance_timers(c);
    // hand-written rows override what the model produced
    if (typed) begin
      tick_fires.delete();
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (fired[s]) begin
          f.slot = SLOT_W'(s);
          f.last = 1'b0;
          tick_fires.push_back(f);
        end
      end
      if (tick_fires.size() != 0) begin
        f = tick_fires[tick_fires.size() - 1];
        f.last = 1'b1;
        tick_fires[tick_fires.size() - 1] = f;
      end
    end
    foreach (tick_fires[k]) pending_fires.push_back(tick_fires[k]);
  endtask

  // result side: stall pattern with one long hold-off
  initial begin : result_sink
    int unsigned span;
    bit          held;
    held = 1'b0;
    forever begin
      if (!held && accepted_cmds >= HOLD_AT) begin
        held = 1'b1;
        span = HOLD_CYCLES;
        res_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        span = $urandom_range(1, 6);
        res_ch.ready <= 1'b0;
      end else begin
        span = $urandom_range(1, 40);
        res_ch.ready <= 1'b1;
      end
      repeat (span) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    fire_t want;
    if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_fires.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat, slot %0d last %0b",
                                res_ch.fired_slot, res_ch.last));
      end else begin
        want = pending_fires.pop_front();
        if (res_ch.fired_slot !== want.slot)
          flag_mismatch($sformatf("fired_slot %0d, expected %0d",
                                  res_ch.fired_slot, want.slot));
        if (res_ch.last !== want.last)
          flag_mismatch($sformatf("last %0b on slot %0d, expected %0b",
                                  res_ch.last, want.slot, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("software_timer_table_unit regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [TIME_W-1:0] wall_ns;
    int unsigned       pick;
    cmd_item_t         c;

    for (int s = 0; s < NUM_SLOTS; s++) begin
      armed[s]     = 1'b0;
      due_ns[s]    = '0;
      span_ns[s]   = '0;
      period_ns[s] = '0;
      periodic[s]  = 1'b0;
      reuse[s]     = 1'b0;
    end
    tick_total    = '0;
    accepted_cmds = 0;
    burst_left    = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    wall_ns       = '0;

    rst_ni                <= 1'b0;
    cmd_ch.valid          <= 1'b0;
    cmd_ch.command        <= CMD_ADD;
    cmd_ch.slot           <= '0;
    cmd_ch.now_ns         <= '0;
    cmd_ch.duration_ns    <= '0;
    cmd_ch.interval_ns    <= '0;
    cmd_ch.is_periodic    <= 1'b0;
    cmd_ch.reuse_duration <= 1'b0;

    // after reset nothing fires, whatever the time
    plan.push_back('{cmd_of(CMD_TICK, 4'd0, '0, '0, '0, 1'b0, 1'b0), 1'b1, 16'h0000});
    plan.push_back('{cmd_of(CMD_TICK, 4'd0, T_MAX, '0, '0, 1'b0, 1'b0), 1'b1, 16'h0000});
    // zero duration one-shot: not due at equal time, due one later, then gone
    plan.push_back('{cmd_of(CMD_ADD, 4'd0, '0, '0, '0, 1'b0, 1'b0), 1'b1, 16'h0000});
    plan.push_back('{cmd_of(CMD_TICK, 4'd0, '0, '0, '0, 1'b0, 1'b0), 1'b1, 16'h0000});
    plan.push_back('{cmd_of(CMD_TICK, 4'd0, 64'd1, '0, '0, 1'b0, 1'b0), 1'b1, 16'h0001});
    plan.push_back('{cmd_of(CMD_TICK, 4'd0, 64'd2, '0, '0, 1'b0, 1'b0), 1'b1, 16'h0000});
    // wrapped deadline, periodic with reused duration
    plan.push_back('{cmd_of(CMD_ADD, 4'd15, T_MAX, T_MAX, '0, 1'b1, 1'b1), 1'b1, 16'h0000});
    plan.push_back('{cmd_of(CMD_TICK, 4'd0, T_MAX, '0, '0, 1'b0, 1'b0), 1'b1, 16'h8000});
    plan.push_back('{cmd_of(CMD_TICK, 4'd0, T_MAX, '0, '0, 1'b0, 1'b0), 1'b1, 16'h8000});
    plan.push_back('{cmd_of(CMD_DELETE, 4'd15, '0, '0, '0, 1'b0, 1'b0), 1'b1, 16'h0000});
    plan.push_back('{cmd_of(CMD_TICK, 4'd0, T_MAX, '0, '0, 1'b0, 1'b0), 1'b1, 16'h0000});
    plan.push_back('{cmd_of(CMD_DELETE, 4'd15, T_MAX, T_MAX, T_MAX, 1'b1, 1'b1), 1'b0, '0});
    // refresh of an active slot
    plan.push_back('{cmd_of(CMD_ADD, 4'd3, 64'd10, 64'd5, T_MAX, 1'b1, 1'b0), 1'b0, '0});
    plan.push_back('{cmd_of(CMD_ADD, 4'd3, 64'd20, 64'd100, 64'd7, 1'b1, 1'b0), 1'b0, '0});
    plan.push_back('{cmd_of(CMD_TICK, 4'd0, 64'd100, '0, '0, 1'b0, 1'b0), 1'b0, '0});
    plan.push_back('{cmd_of(CMD_TICK, 4'd0, 64'd121, '0, '0, 1'b0, 1'b0), 1'b0, '0});
    // spare code does nothing
    plan.push_back('{cmd_of(CMD_SPARE, 4'd3, T_MAX, T_MAX, T_MAX, 1'b1, 1'b1), 1'b0, '0});
    plan.push_back('{cmd_of(CMD_ADD, 4'd7, '0, '0, '0, 1'b0, 1'b0), 1'b0, '0});
    plan.push_back('{cmd_of(CMD_ADD, 4'd8, '0, '0, T_MAX, 1'b1, 1'b0), 1'b0, '0});
    plan.push_back('{cmd_of(CMD_TICK, 4'd0, 64'd200, '0, '0, 1'b0, 1'b0), 1'b0, '0});
    plan.push_back('{cmd_of(CMD_TICK, 4'd0, 64'd200, '0, '0, 1'b0, 1'b0), 1'b0, '0});
    plan.push_back('{cmd_of(CMD_DELETE, 4'd3, '0, '0, '0, 1'b0, 1'b0), 1'b0, '0});
    plan.push_back('{cmd_of(CMD_DELETE, 4'd8, '0, '0, '0, 1'b0, 1'b0), 1'b0, '0});
    plan.push_back('{cmd_of(CMD_TICK, 4'd0, T_MAX, '0, '0, 1'b0, 1'b0), 1'b0, '0});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) issue_cmd(plan[r].item, plan[r].typed, plan[r].fired);

    while (accepted_cmds < plan.size() + RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        c = cmd_of(CMD_ADD, SLOT_W'($urandom), wall_ns, TIME_W'($urandom_range(0, 40)),
                   TIME_W'($urandom_range(0, 40)), 1'($urandom), 1'($urandom));
        issue_cmd(c, 1'b0, '0);
      end else if (pick < 70) begin
        wall_ns = wall_ns + $urandom_range(0, 30);
        issue_cmd(cmd_of(CMD_TICK, SLOT_W'($urandom), wall_ns, rand_time(), rand_time(),
                         1'($urandom), 1'($urandom)), 1'b0, '0);
      end else if (pick < 75) begin
        issue_cmd(cmd_of(CMD_DELETE, SLOT_W'($urandom), rand_time(), rand_time(),
                         rand_time(), 1'($urandom), 1'($urandom)), 1'b0, '0);
      end else if (pick < 80) begin
        issue_cmd(cmd_of(CMD_ADD, SLOT_W'($urandom), rand_time(), rand_time(),
                         rand_time(), 1'($urandom), 1'($urandom)), 1'b0, '0);
      end else if (pick < 84) begin
        issue_cmd(cmd_of(CMD_TICK, SLOT_W'($urandom), rand_time(), rand_time(),
                         rand_time(), 1'($urandom), 1'($urandom)), 1'b0, '0);
      end else if (pick < 87) begin
        issue_cmd(cmd_of(CMD_SPARE, SLOT_W'($urandom), rand_time(), rand_time(),
                         rand_time(), 1'($urandom), 1'($urandom)), 1'b0, '0);
      end else if (pick < 91) begin
        // whole table due on one tick
        for (int s = 0; s < NUM_SLOTS; s++) begin
          c = cmd_of(CMD_ADD, SLOT_W'(s), wall_ns, '0, TIME_W'($urandom_range(0, 20)),
                     1'($urandom), 1'($urandom));
          issue_cmd(c, 1'b0, '0);
        end
        wall_ns = wall_ns + 1'b1;
        issue_cmd(cmd_of(CMD_TICK, '0, wall_ns, '0, '0, 1'b0, 1'b0), 1'b0, '0);
      end else if (pick < 94) begin
        wall_ns = T_MAX - $urandom_range(0, 200);
      end else begin
        issue_cmd(cmd_of(CMD_TICK, '0, wall_ns, '0, '0, 1'b0, 1'b0), 1'b0, '0);
      end
    end

    cmd_ch.valid <= 1'b0;
    while (pending_fires.size() != 0) @(posedge clk_i);
    repeat (2 * NUM_SLOTS + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("software_timer_table_unit regression: pass");
    end else begin
      $display("software_timer_table_unit regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
